FILE: rtl/core/hlc_pkg.sv
// Shared types and character constants for the HTTP request line checker.
package hlc_pkg;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_SP   = 8'h20;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_ONE  = 8'h31;

  localparam logic [2:0] METHOD_LEN  = 3'd3;
  localparam logic [2:0] METHOD_OVER = 3'd4;
  localparam logic [3:0] VERSION_PREFIX_LEN = 4'd7;
  localparam logic [3:0] VERSION_LEN  = 4'd8;
  localparam logic [3:0] VERSION_OVER = 4'd9;

  localparam logic [1:0] FIELD_METHOD  = 2'd0;
  localparam logic [1:0] FIELD_URL     = 2'd1;
  localparam logic [1:0] FIELD_VERSION = 2'd2;
  localparam logic [1:0] FIELD_EXTRA   = 2'd3;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       last_byte;
  } hlc_req_t;

  typedef struct packed {
    logic       url_byte_valid;
    logic [7:0] url_byte;
    logic       line_done;
    logic       request_bad;
    logic       version_minor;
  } hlc_rsp_t;

  // Expected method text "GET", indexed by position.
  function automatic logic [7:0] method_char(input logic [1:0] pos);
    logic [7:0] c;
    unique case (pos)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Expected version prefix "HTTP/1.", indexed by position.
  function automatic logic [7:0] version_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h48;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h50;
      3'd4:    c = 8'h2F;
      3'd5:    c = 8'h31;
      3'd6:    c = 8'h2E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/http_request_line_checker.sv
// Top level of the HTTP request line checker: byte parser with a skid-buffered result.
//
// Usage: one byte of a request line enters per transaction on the req channel
// (req_valid, req_stall, req), with last_byte set on the final byte of the
// line. Every accepted byte gives exactly one result transaction on the rsp
// channel (rsp_valid, rsp_stall, rsp). URL bytes are echoed with
// url_byte_valid set; the result of the byte marked last carries line_done,
// request_bad and version_minor, and the parser then starts a new line.
// An accepted byte's result is registered in the output register, or in the skid
// register while rsp_stall holds. Throughput is one byte per cycle while req_stall is
// low, set by the single register stage holding both parse state and result.
// While rsp_stall is high a skid register takes one more result, after which
// req_stall rises until the output drains; no result is lost or repeated.
// rst is synchronous and active high: it clears the parse state to the start
// of a line and empties the output and skid registers.
module http_request_line_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  hlc_pkg::hlc_req_t  req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output hlc_pkg::hlc_rsp_t  rsp
);
  import hlc_pkg::*;

  logic [1:0] field_number, field_number_next;
  logic       previous_was_space, previous_was_space_next;
  logic       at_line_start, at_line_start_next;
  logic       stopped_by_return, stopped_by_return_next;
  logic       spacing_error, spacing_error_next;
  logic [2:0] method_position, method_position_next;
  logic       method_mismatch, method_mismatch_next;
  logic [3:0] version_position, version_position_next;
  logic       version_mismatch, version_mismatch_next;
  logic       minor_digit, minor_digit_next;
  logic       url_seen, url_seen_next;

  logic       skid_valid;
  hlc_rsp_t   skid;
  hlc_rsp_t   result;
  logic       accept;
  logic       echo;
  logic       method_ok, version_ok, bad;

  assign req_stall = skid_valid;
  assign accept    = req_valid && !skid_valid;

  always_comb begin
    field_number_next       = field_number;
    previous_was_space_next = previous_was_space;
    at_line_start_next      = at_line_start;
    stopped_by_return_next  = stopped_by_return;
    spacing_error_next      = spacing_error;
    method_position_next    = method_position;
    method_mismatch_next    = method_mismatch;
    version_position_next   = version_position;
    version_mismatch_next   = version_mismatch;
    minor_digit_next        = minor_digit;
    url_seen_next           = url_seen;
    echo                    = 1'b0;

    if (!stopped_by_return) begin
      if (req.line_byte == CHAR_CR) begin
        stopped_by_return_next = 1'b1;
      end else if (req.line_byte == CHAR_SP) begin
        if (at_line_start || previous_was_space) spacing_error_next = 1'b1;
        if (field_number != FIELD_EXTRA) field_number_next = field_number + 2'd1;
        previous_was_space_next = 1'b1;
        at_line_start_next      = 1'b0;
      end else begin
        case (field_number)
          FIELD_METHOD: begin
            if (method_position < METHOD_LEN) begin
              if (req.line_byte != method_char(method_position[1:0])) begin
                method_mismatch_next = 1'b1;
              end
              method_position_next = method_position + 3'd1;
            end else begin
              method_mismatch_next = 1'b1;
              method_position_next = METHOD_OVER;
            end
          end
          FIELD_URL: begin
            url_seen_next = 1'b1;
            echo          = 1'b1;
          end
          FIELD_VERSION: begin
            if (version_position < VERSION_PREFIX_LEN) begin
              if (req.line_byte != version_char(version_position[2:0])) begin
                version_mismatch_next = 1'b1;
              end
              version_position_next = version_position + 4'd1;
            end else if (version_position == VERSION_PREFIX_LEN) begin
              if (req.line_byte == CHAR_ZERO) minor_digit_next = 1'b0;
              else if (req.line_byte == CHAR_ONE) minor_digit_next = 1'b1;
              else version_mismatch_next = 1'b1;
              version_position_next = VERSION_LEN;
            end else begin
              version_mismatch_next = 1'b1;
              version_position_next = VERSION_OVER;
            end
          end
          default: begin
          end
        endcase
        previous_was_space_next = 1'b0;
        at_line_start_next      = 1'b0;
      end
    end

    // The verdict covers this byte as well, so it uses the updated state
    // before the line is cleared.
    method_ok  = !method_mismatch_next && (method_position_next == METHOD_LEN);
    version_ok = !version_mismatch_next && (version_position_next == VERSION_LEN);
    bad        = spacing_error_next || !method_ok || !version_ok || !url_seen_next;

    result.url_byte_valid = echo;
    result.url_byte       = echo ? req.line_byte : 8'h00;
    result.line_done      = req.last_byte;
    result.request_bad    = req.last_byte && bad;
    result.version_minor  = req.last_byte && !bad && minor_digit_next;

    if (req.last_byte) begin
      field_number_next       = FIELD_METHOD;
      previous_was_space_next = 1'b0;
      at_line_start_next      = 1'b1;
      stopped_by_return_next  = 1'b0;
      spacing_error_next      = 1'b0;
      method_position_next    = 3'd0;
      method_mismatch_next    = 1'b0;
      version_position_next   = 4'd0;
      version_mismatch_next   = 1'b0;
      minor_digit_next        = 1'b0;
      url_seen_next           = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_number       <= FIELD_METHOD;
      previous_was_space <= 1'b0;
      at_line_start      <= 1'b1;
      stopped_by_return  <= 1'b0;
      spacing_error      <= 1'b0;
      method_position    <= 3'd0;
      method_mismatch    <= 1'b0;
      version_position   <= 4'd0;
      version_mismatch   <= 1'b0;
      minor_digit        <= 1'b0;
      url_seen           <= 1'b0;
    end else if (accept) begin
      field_number       <= field_number_next;
      previous_was_space <= previous_was_space_next;
      at_line_start      <= at_line_start_next;
      stopped_by_return  <= stopped_by_return_next;
      spacing_error      <= spacing_error_next;
      method_position    <= method_position_next;
      method_mismatch    <= method_mismatch_next;
      version_position   <= version_position_next;
      version_mismatch   <= version_mismatch_next;
      minor_digit        <= minor_digit_next;
      url_seen           <= url_seen_next;
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!rsp_valid || !rsp_stall) begin
      if (skid_valid) begin
        rsp        <= skid;
        rsp_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        rsp_valid <= accept;
        if (accept) rsp <= result;
      end
    end else if (accept) begin
      skid       <= result;
      skid_valid <= 1'b1;
    end
  end

endmodule
